FILE: rtl/core/csym_pkg.sv
// ----------------------------------------------------------------------------
// csym_pkg
// Shared types and constants of the color symbol receiver: code values,
// datapath widths, luminance weights and the eight-entry BGR palette.
// ----------------------------------------------------------------------------
package csym_pkg;

  localparam int unsigned CHAN_W = 8;
  localparam int unsigned SQ_W   = 2 * CHAN_W;
  // max squared distance is 3 * 255^2 = 195075, limit^2 at most 511^2
  localparam int unsigned DIST_W = 18;
  // max weighted luminance and threshold are 1000 * 255 = 255000
  localparam int unsigned LUMA_W = 18;
  localparam int unsigned CODE_W = 4;
  localparam int unsigned SYM_W  = 3;
  localparam int unsigned RUN_W  = 8;
  localparam int unsigned NUM_COLORS = 8;

  localparam logic [CODE_W-1:0] CODE_NONE    = 4'd15;
  localparam logic [CODE_W-1:0] CODE_NOMATCH = 4'd8;
  localparam logic [RUN_W-1:0]  RUN_MAX      = 8'd255;

  // luminance in thousandths
  localparam logic [9:0] LUMA_WB     = 10'd114;
  localparam logic [9:0] LUMA_WG     = 10'd587;
  localparam logic [9:0] LUMA_WR     = 10'd299;
  localparam logic [9:0] LUMA_SCALE  = 10'd1000;

  // per palette entry: bit 0 blue, bit 1 green, bit 2 red is at full scale
  localparam logic [NUM_COLORS-1:0][2:0] PALETTE = {
    3'b011,  // cyan
    3'b110,  // yellow
    3'b101,  // magenta
    3'b010,  // green
    3'b001,  // blue
    3'b100,  // red
    3'b111,  // white
    3'b000   // black
  };

  typedef enum logic [1:0] {
    REG_MODE_OCTAL,
    REG_STABLE_FRAMES,
    REG_LUMA_THRESHOLD,
    REG_DISTANCE_LIMIT
  } cfg_reg_t;

  // results of the first decode stage
  typedef struct packed {
    logic [NUM_COLORS-1:0][DIST_W-1:0] sq_dist;
    logic [DIST_W-1:0]                 limit_sq;
    logic                              luma_low;
  } metric_t;

endpackage

FILE: rtl/core/color_symbol_receiver.sv
// ----------------------------------------------------------------------------
// color_symbol_receiver
// Decodes averaged BGR samples into binary or eight-color symbols and
// debounces them with a saturating run counter.
//
//   channel  dir  signals                       contents
//   s        in   s_tvalid s_tready s_tdata     one BGR sample
//   m        out  m_tvalid m_tready m_tdata     symbol, valid, run, accepted
//   cfg      in   cfg_wen cfg_index cfg_data    register write
//
// one request per cycle sustained while m_tready stays high; a result passes in turn
// through the input register, the distance/luminance register and the result register
// the run counter updates as each item leaves the second register
// every stage holds while the next is full and stalled; a full result
// register still frees the earlier stages when m_tready is high
// synchronous reset clears stage valids and run state and restores the default configuration
// ----------------------------------------------------------------------------
module color_symbol_receiver
  import csym_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,    // blue[7:0], green[15:8], red[23:16]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,    // symbol[2:0], symbol_valid[3],
                                  // run_length[11:4], accepted[12], zero[15:13]
  input  logic        cfg_wen,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  // configuration
  logic        mode_octal;
  logic [7:0]  stable_frames;
  logic [7:0]  luma_threshold;
  logic [8:0]  distance_limit;

  // pipeline
  logic              in_valid;
  logic [23:0]       in_data;
  logic              mid_valid;
  metric_t           mid_metric;
  metric_t           metric_next;
  logic              out_valid;
  logic [15:0]       out_data;
  logic              in_ready;
  logic              mid_ready;
  logic              out_ready;

  // run state
  logic [CODE_W-1:0] last_code;
  logic [RUN_W-1:0]  run_count;
  logic [CODE_W-1:0] code;
  logic              sym_valid;
  logic [RUN_W-1:0]  run_next;
  logic              accept_sym;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_octal     <= 1'b0;
      stable_frames  <= 8'd3;
      luma_threshold <= 8'd128;
      distance_limit <= 9'd120;
    end else if (cfg_wen) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MODE_OCTAL:     mode_octal     <= cfg_data[0];
        REG_STABLE_FRAMES:  stable_frames  <= cfg_data[7:0];
        REG_LUMA_THRESHOLD: luma_threshold <= cfg_data[7:0];
        REG_DISTANCE_LIMIT: distance_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_ready = !out_valid || m_tready;
  assign mid_ready = !mid_valid || out_ready;
  assign in_ready  = !in_valid || mid_ready;
  assign s_tready  = in_ready;

  csym_metric u_metric (
    .blue           (in_data[7:0]),
    .green          (in_data[15:8]),
    .red            (in_data[23:16]),
    .luma_threshold (luma_threshold),
    .distance_limit (distance_limit),
    .metric         (metric_next)
  );

  csym_select u_select (
    .metric     (mid_metric),
    .mode_octal (mode_octal),
    .code       (code)
  );

  assign sym_valid = (code != CODE_NOMATCH);

  always_comb begin
    if (code != last_code) begin
      run_next = RUN_W'(1);
    end else if (run_count == RUN_MAX) begin
      run_next = RUN_MAX;
    end else begin
      run_next = run_count + RUN_W'(1);
    end
  end

  assign accept_sym = sym_valid && (run_next >= stable_frames);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      mid_valid <= 1'b0;
      out_valid <= 1'b0;
      last_code <= CODE_NONE;
      run_count <= '0;
    end else begin
      if (in_ready) begin
        in_valid <= s_tvalid;
      end
      if (mid_ready) begin
        mid_valid <= in_valid;
      end
      if (out_ready) begin
        out_valid <= mid_valid;
      end
      if (mid_valid && out_ready) begin
        // an accepted symbol restarts the run from nothing
        last_code <= accept_sym ? CODE_NONE : code;
        run_count <= accept_sym ? '0 : run_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && s_tvalid) begin
      in_data <= s_tdata;
    end
    if (mid_ready && in_valid) begin
      mid_metric <= metric_next;
    end
    if (out_ready && mid_valid) begin
      out_data <= {3'b000, accept_sym, run_next, sym_valid,
                   sym_valid ? code[SYM_W-1:0] : SYM_W'(0)};
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  // an empty result register never blocks new requests
  assert property (@(posedge clk) disable iff (rst) !m_tvalid |-> s_tready)
    else $error("input stalled with empty result register");

  // run count and last code are cleared together and set together
  assert property (@(posedge clk) disable iff (rst)
    (run_count == '0) == (last_code == CODE_NONE))
    else $error("run state inconsistent");

  // acceptance clears the run state
  assert property (@(posedge clk) disable iff (rst)
    (mid_valid && out_ready && accept_sym) |=>
      (run_count == '0 && last_code == CODE_NONE))
    else $error("run not restarted after acceptance");

endmodule

FILE: rtl/core/csym_metric.sv
// ----------------------------------------------------------------------------
// csym_metric
// Squared distances of one BGR sample to every palette color, the squared
// distance limit and the luminance-below-threshold bit.
// ----------------------------------------------------------------------------
module csym_metric
  import csym_pkg::*;
(
  input  logic [CHAN_W-1:0] blue,
  input  logic [CHAN_W-1:0] green,
  input  logic [CHAN_W-1:0] red,
  input  logic [7:0]        luma_threshold,
  input  logic [8:0]        distance_limit,
  output metric_t           metric
);

  logic [2:0][CHAN_W-1:0] comp;
  logic [2:0][SQ_W-1:0]   sq_lo;
  logic [2:0][SQ_W-1:0]   sq_hi;
  logic [CHAN_W-1:0]      comp_inv;
  logic [LUMA_W-1:0]      luma;
  logic [LUMA_W-1:0]      luma_limit;

  assign comp = {red, green, blue};

  // palette components are all 0 or 255, so two squares per channel suffice
  always_comb begin
    comp_inv = '0;
    for (int ch = 0; ch < 3; ch++) begin
      comp_inv  = 8'd255 - comp[ch];
      sq_lo[ch] = SQ_W'(comp[ch]) * SQ_W'(comp[ch]);
      sq_hi[ch] = SQ_W'(comp_inv) * SQ_W'(comp_inv);
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_COLORS; i++) begin
      metric.sq_dist[i] = DIST_W'(PALETTE[i][0] ? sq_hi[0] : sq_lo[0])
                        + DIST_W'(PALETTE[i][1] ? sq_hi[1] : sq_lo[1])
                        + DIST_W'(PALETTE[i][2] ? sq_hi[2] : sq_lo[2]);
    end
  end

  assign luma = LUMA_W'(blue) * LUMA_W'(LUMA_WB)
              + LUMA_W'(green) * LUMA_W'(LUMA_WG)
              + LUMA_W'(red) * LUMA_W'(LUMA_WR);
  assign luma_limit = LUMA_W'(luma_threshold) * LUMA_W'(LUMA_SCALE);

  assign metric.luma_low = (luma < luma_limit);
  assign metric.limit_sq = DIST_W'(distance_limit) * DIST_W'(distance_limit);

endmodule

FILE: rtl/core/csym_select.sv
// ----------------------------------------------------------------------------
// csym_select
// Picks the nearest palette color with a three-level compare tree, checks it
// against the distance limit and forms the decode code for either mode.
// ----------------------------------------------------------------------------
module csym_select
  import csym_pkg::*;
(
  input  metric_t           metric,
  input  logic              mode_octal,
  output logic [CODE_W-1:0] code
);

  logic [3:0][DIST_W-1:0] l1_dist;
  logic [3:0][SYM_W-1:0]  l1_idx;
  logic [1:0][DIST_W-1:0] l2_dist;
  logic [1:0][SYM_W-1:0]  l2_idx;
  logic [DIST_W-1:0]      best_dist;
  logic [SYM_W-1:0]       best_idx;

  // the right side wins only when strictly nearer, so ties keep the lower index
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (metric.sq_dist[2*i+1] < metric.sq_dist[2*i]) begin
        l1_dist[i] = metric.sq_dist[2*i+1];
        l1_idx[i]  = SYM_W'(2*i+1);
      end else begin
        l1_dist[i] = metric.sq_dist[2*i];
        l1_idx[i]  = SYM_W'(2*i);
      end
    end
    for (int i = 0; i < 2; i++) begin
      if (l1_dist[2*i+1] < l1_dist[2*i]) begin
        l2_dist[i] = l1_dist[2*i+1];
        l2_idx[i]  = l1_idx[2*i+1];
      end else begin
        l2_dist[i] = l1_dist[2*i];
        l2_idx[i]  = l1_idx[2*i];
      end
    end
    if (l2_dist[1] < l2_dist[0]) begin
      best_dist = l2_dist[1];
      best_idx  = l2_idx[1];
    end else begin
      best_dist = l2_dist[0];
      best_idx  = l2_idx[0];
    end
  end

  always_comb begin
    if (!mode_octal) begin
      code = CODE_W'(metric.luma_low);
    end else if (best_dist <= metric.limit_sq) begin
      code = {1'b0, best_idx};
    end else begin
      code = CODE_NOMATCH;
    end
  end

endmodule

FILE: tb/color_symbol_receiver_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// color_symbol_receiver_tb
// Drives BGR samples through the receiver under random stalls on both sides,
// predicts every result with a local model of the decoder and run counter,
// and compares each result field by field in order.
// ----------------------------------------------------------------------------
module color_symbol_receiver_tb
  import csym_pkg::*;
();

  localparam int CYCLE_LIMIT  = 100000;
  localparam int HOLD_CYCLES  = 200;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } sample_t;

  typedef struct packed {
    logic [2:0] pad;
    logic       accepted;
    logic [7:0] run_length;
    logic       symbol_valid;
    logic [2:0] symbol;
  } symbol_t;

  // full-scale channels of each palette color, {blue, green, red}
  function automatic logic [2:0] palette_corner(int idx);
    case (idx)
      0: return 3'b000;
      1: return 3'b111;
      2: return 3'b001;
      3: return 3'b100;
      4: return 3'b010;
      5: return 3'b101;
      6: return 3'b011;
      default: return 3'b110;
    endcase
  endfunction

  class symbol_scoreboard;
    bit         mode_octal;
    logic [7:0] stable_frames;
    logic [7:0] luma_threshold;
    logic [8:0] distance_limit;
    logic [3:0] last_code;
    logic [7:0] run_count;
    symbol_t    expected_symbols[$];
    int         mismatches;

    function new();
      mode_octal     = 1'b0;
      stable_frames  = 8'd3;
      luma_threshold = 8'd128;
      distance_limit = 9'd120;
      last_code      = CODE_NONE;
      run_count      = '0;
      mismatches     = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [8:0] value);
      case (cfg_reg_t'(idx))
        REG_MODE_OCTAL:     mode_octal     = value[0];
        REG_STABLE_FRAMES:  stable_frames  = value[7:0];
        REG_LUMA_THRESHOLD: luma_threshold = value[7:0];
        REG_DISTANCE_LIMIT: distance_limit = value;
        default: ;
      endcase
    endfunction

    function logic [3:0] classify(sample_t s);
      int unsigned luma;
      int          db, dg, dr, sq_dist, best_dist;
      logic [2:0]  corner;
      logic [3:0]  best;
      if (!mode_octal) begin
        luma = 114 * s.blue + 587 * s.green + 299 * s.red;
        return (luma < 1000 * luma_threshold) ? 4'd1 : 4'd0;
      end
      best      = '0;
      best_dist = 32'h7fffffff;
      for (int i = 0; i < 8; i++) begin
        corner = palette_corner(i);
        db = int'(s.blue)  - (corner[2] ? 255 : 0);
        dg = int'(s.green) - (corner[1] ? 255 : 0);
        dr = int'(s.red)   - (corner[0] ? 255 : 0);
        sq_dist = db * db + dg * dg + dr * dr;
        // strict compare keeps the lower index on a tie
        if (sq_dist < best_dist) begin
          best_dist = sq_dist;
          best      = i[3:0];
        end
      end
      if (best_dist <= int'(distance_limit) * int'(distance_limit))
        return best;
      return CODE_NOMATCH;
    endfunction

    function void note_sample(logic [23:0] data);
      sample_t    s;
      logic [3:0] code;
      symbol_t    want;
      s    = data;
      code = classify(s);
      if (code == last_code) begin
        if (run_count != RUN_MAX)
          run_count = run_count + 8'd1;
      end else begin
        last_code = code;
        run_count = 8'd1;
      end
      want              = '0;
      want.symbol_valid = (code != CODE_NOMATCH);
      want.symbol       = want.symbol_valid ? code[2:0] : 3'd0;
      want.run_length   = run_count;
      want.accepted     = want.symbol_valid && (run_count >= stable_frames);
      if (want.accepted) begin
        last_code = CODE_NONE;
        run_count = '0;
      end
      expected_symbols.push_back(want);
    endfunction

    function void flag(string what, symbol_t want, symbol_t got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
        $write("%0t: %s: expected sym=%0d ok=%0d run=%0d acc=%0d pad=%0d, ",
               $time, what, want.symbol, want.symbol_valid, want.run_length,
               want.accepted, want.pad);
        $display("got sym=%0d ok=%0d run=%0d acc=%0d pad=%0d",
                 got.symbol, got.symbol_valid, got.run_length, got.accepted,
                 got.pad);
      end
    endfunction

    function void check_result(logic [15:0] data);
      symbol_t got;
      symbol_t want;
      got = data;
      if (expected_symbols.size() == 0) begin
        flag("unexpected result", '0, got);
        return;
      end
      want = expected_symbols.pop_front();
      if (got.symbol !== want.symbol || got.symbol_valid !== want.symbol_valid ||
          got.run_length !== want.run_length || got.accepted !== want.accepted ||
          got.pad !== want.pad)
        flag("result mismatch", want, got);
    endfunction

    function int pending();
      return expected_symbols.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;     // blue[7:0], green[15:8], red[23:16]
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;     // symbol[2:0], symbol_valid[3], run_length[11:4],
                            // accepted[12], zero[15:13]
  logic        cfg_wen;
  logic [1:0]  cfg_index;
  logic [8:0]  cfg_data;

  symbol_scoreboard sb = new();
  int      cycle_count = 0;
  bit      quiet = 1'b0;
  bit      hold_req = 1'b0;
  sample_t prev_sample = '0;

  color_symbol_receiver dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && cfg_wen)
      sb.write_reg(cfg_index, cfg_data);
    if (!rst && s_tvalid && s_tready)
      sb.note_sample(s_tdata);
    if (!rst && m_tvalid && m_tready)
      sb.check_result(m_tdata);
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      m_tready <= quiet || ($urandom_range(99) >= 34);
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [8:0] value);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_wen   <= 1'b0;
  endtask

  task automatic set_config(input bit octal, input logic [7:0] frames,
                            input logic [7:0] thr, input logic [8:0] lim);
    write_reg(REG_MODE_OCTAL, {8'd0, octal});
    write_reg(REG_STABLE_FRAMES, {1'b0, frames});
    write_reg(REG_LUMA_THRESHOLD, {1'b0, thr});
    write_reg(REG_DISTANCE_LIMIT, lim);
  endtask

  task automatic send_sample(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r);
    @(negedge clk);
    if (!quiet && $urandom_range(99) < 34) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {r, g, b};
    do @(posedge clk); while (!s_tready);
    prev_sample = {r, g, b};
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [7:0] jitter(logic [7:0] level, int spread);
    int v;
    v = int'(level) + int'($urandom_range(2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  // mostly repeats and near-palette colors so runs build up and accept, unless noise_only
  task automatic send_random(input bit noise_only);
    int         pick;
    int         spread;
    logic [2:0] corner;
    sample_t    s;
    pick = $urandom_range(99);
    if (noise_only || pick < 25) begin
      s = 24'($urandom());
    end else if (pick < 70) begin
      s = prev_sample;
    end else begin
      corner = palette_corner($urandom_range(7));
      spread = $urandom_range(1, 70);
      s.blue  = jitter(corner[2] ? 8'd255 : 8'd0, spread);
      s.green = jitter(corner[1] ? 8'd255 : 8'd0, spread);
      s.red   = jitter(corner[0] ? 8'd255 : 8'd0, spread);
    end
    send_sample(s.blue, s.green, s.red);
  endtask

  task automatic random_phase(input int count, input bit noise_only);
    for (int i = 0; i < count; i++)
      send_random(noise_only);
    drain();
  endtask

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cfg_wen   = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // binary decode at reset settings, threshold boundary and a debounced run
    send_sample(8'd0, 8'd0, 8'd0);
    send_sample(8'd255, 8'd255, 8'd255);
    send_sample(8'd128, 8'd128, 8'd128);
    repeat (3) send_sample(8'd127, 8'd127, 8'd127);
    send_sample(8'd255, 8'd0, 8'd0);
    send_sample(8'd0, 8'd255, 8'd0);
    send_sample(8'd0, 8'd0, 8'd255);
    drain();

    // every palette color, then the distance limit boundary
    set_config(1'b1, 8'd1, 8'd128, 9'd120);
    for (int i = 0; i < 8; i++) begin
      logic [2:0] corner;
      corner = palette_corner(i);
      send_sample(corner[2] ? 8'd255 : 8'd0, corner[1] ? 8'd255 : 8'd0,
                  corner[0] ? 8'd255 : 8'd0);
    end
    send_sample(8'd0, 8'd0, 8'd120);
    send_sample(8'd0, 8'd0, 8'd121);
    send_sample(8'd127, 8'd127, 8'd127);
    drain();

    // limit past the cube diagonal matches everything, zero frames accepts all
    set_config(1'b1, 8'd0, 8'd128, 9'd511);
    send_sample(8'd128, 8'd128, 8'd128);
    send_sample(8'd128, 8'd127, 8'd128);
    drain();

    // luminance threshold extremes, also a threshold change in the middle of a run
    set_config(1'b0, 8'd3, 8'd0, 9'd511);
    send_sample(8'd0, 8'd0, 8'd0);
    drain();
    write_reg(REG_LUMA_THRESHOLD, 9'd255);
    send_sample(8'd255, 8'd255, 8'd254);
    send_sample(8'd255, 8'd255, 8'd255);
    drain();

    set_config(1'b0, 8'd3, 8'd128, 9'd120);
    random_phase(150, 1'b0);

    set_config(1'b1, 8'd2, 8'd90, 9'd120);
    hold_req = 1'b1;
    random_phase(150, 1'b0);

    quiet = 1'b1;
    set_config(1'b1, 8'd5, 8'd200, 9'd60);
    random_phase(150, 1'b0);
    quiet = 1'b0;

    // zero limit: random samples never match, so the run counter saturates
    set_config(1'b1, 8'd1, 8'd40, 9'd0);
    random_phase(280, 1'b1);

    set_config(1'b0, 8'd1, 8'd255, 9'd300);
    random_phase(100, 1'b0);

    set_config(1'b1, 8'd255, 8'd17, 9'd442);
    random_phase(50, 1'b0);
    write_reg(REG_STABLE_FRAMES, 9'd0);
    random_phase(50, 1'b0);

    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/csym_pkg.sv
rtl/core/csym_metric.sv
rtl/core/csym_select.sv
rtl/core/color_symbol_receiver.sv
tb/color_symbol_receiver_tb.sv
